/* src/dpts_pkg.sv */
// Package for the DMA put transfer splitter: field widths, payload structs,
// microcode word layout and the microcode program itself.
// Used by dpts_sequencer, dpts_datapath and dma_put_transfer_splitter_top.
`timescale 1ns / 1ps

package dpts_pkg;

  localparam int EXT_W       = 64;
  localparam int LOC_W       = 18;
  localparam int CNT_W       = 16;
  localparam int TAG_W       = 5;
  localparam int LEN_W       = 15;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS);
  localparam int PC_W        = 3;

  localparam int MAX_DMA_BYTES_DEF     = 16384;
  localparam int MAX_REQUEST_BYTES_DEF = 65535;

  typedef struct packed {
    logic [EXT_W-1:0] ext_addr;
    logic [LOC_W-1:0] local_addr;
    logic [CNT_W-1:0] byte_count;
    logic [TAG_W-1:0] tag;
  } dpts_in_t;

  typedef struct packed {
    logic [EXT_W-1:0] xfer_ext_addr;
    logic [LOC_W-1:0] xfer_local_addr;
    logic [LEN_W-1:0] xfer_len;
    logic [TAG_W-1:0] xfer_tag;
    logic             last;
  } dpts_out_t;

  // Operation of one microcode step.
  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PIECE = 2'd2,
    OP_CHUNK = 2'd3
  } dpts_op_e;

  // Exit condition of one microcode step.
  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_REM_ZERO = 3'd1,
    COND_SHORT    = 3'd2,
    COND_ALIGNED  = 3'd3,
    COND_REM_LT16 = 3'd4
  } dpts_cond_e;

  // Step addresses of the program.
  localparam logic [PC_W-1:0] PC_LOAD   = 3'd0;
  localparam logic [PC_W-1:0] PC_EMPTY  = 3'd1;
  localparam logic [PC_W-1:0] PC_MODE   = 3'd2;
  localparam logic [PC_W-1:0] PC_PREFIX = 3'd3;
  localparam logic [PC_W-1:0] PC_CHUNK  = 3'd4;
  localparam logic [PC_W-1:0] PC_TAIL   = 3'd5;

  typedef struct packed {
    dpts_cond_e      cond;
    logic [PC_W-1:0] exit_pc;
    dpts_op_e        op;
    logic [PC_W-1:0] next_pc;
  } dpts_cw_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic rem_zero;
    logic is_short;
    logic ea_aligned;
    logic rem_lt16;
    logic last_piece;
    logic last_chunk;
  } dpts_status_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load_slot;
    logic emit;
    logic chunk;
  } dpts_ctrl_t;

  // The program. When the exit condition holds, the step jumps to exit_pc
  // and does nothing else; otherwise it runs its operation and, once that
  // completes, goes to next_pc, or to PC_LOAD after the transfer with last.
  function automatic dpts_cw_t dpts_ucode(input logic [PC_W-1:0] pc);
    dpts_cw_t cw;
    unique case (pc)
      PC_LOAD:   cw = '{COND_NEVER,    PC_LOAD,  OP_LOAD,  PC_EMPTY};
      PC_EMPTY:  cw = '{COND_REM_ZERO, PC_LOAD,  OP_NOP,   PC_MODE};
      PC_MODE:   cw = '{COND_SHORT,    PC_TAIL,  OP_NOP,   PC_PREFIX};
      PC_PREFIX: cw = '{COND_ALIGNED,  PC_CHUNK, OP_PIECE, PC_PREFIX};
      PC_CHUNK:  cw = '{COND_REM_LT16, PC_TAIL,  OP_CHUNK, PC_CHUNK};
      PC_TAIL:   cw = '{COND_REM_ZERO, PC_LOAD,  OP_PIECE, PC_TAIL};
      default:   cw = '{COND_NEVER,    PC_LOAD,  OP_NOP,   PC_LOAD};
    endcase
    return cw;
  endfunction

endpackage

/* src/dpts_sequencer.sv */
// Microcode sequencer of the DMA put transfer splitter: step counter,
// program lookup and conditional jumps. Depends on dpts_pkg.
`timescale 1ns / 1ps

module dpts_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dpts_pkg::dpts_status_t status_i,
  output dpts_pkg::dpts_ctrl_t   ctrl_o
);

  logic [dpts_pkg::PC_W-1:0] pc_q, pc_d;
  dpts_pkg::dpts_cw_t        cw;
  logic                      cond_hit;
  logic                      op_done;
  logic                      is_last;

  assign cw = dpts_pkg::dpts_ucode(pc_q);

  always_comb begin
    unique case (cw.cond)
      dpts_pkg::COND_NEVER:    cond_hit = 1'b0;
      dpts_pkg::COND_REM_ZERO: cond_hit = status_i.rem_zero;
      dpts_pkg::COND_SHORT:    cond_hit = status_i.is_short;
      dpts_pkg::COND_ALIGNED:  cond_hit = status_i.ea_aligned;
      dpts_pkg::COND_REM_LT16: cond_hit = status_i.rem_lt16;
      default:                 cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.op)
      dpts_pkg::OP_NOP:   op_done = 1'b1;
      dpts_pkg::OP_LOAD:  op_done = status_i.in_valid;
      dpts_pkg::OP_PIECE: op_done = status_i.out_free;
      dpts_pkg::OP_CHUNK: op_done = status_i.out_free;
      default:            op_done = 1'b1;
    endcase
  end

  assign ctrl_o.load_slot = (cw.op == dpts_pkg::OP_LOAD);
  assign ctrl_o.chunk     = (cw.op == dpts_pkg::OP_CHUNK);
  assign ctrl_o.emit      = !cond_hit && op_done &&
                            ((cw.op == dpts_pkg::OP_PIECE) || (cw.op == dpts_pkg::OP_CHUNK));

  assign is_last = ctrl_o.chunk ? status_i.last_chunk : status_i.last_piece;

  always_comb begin
    pc_d = pc_q;
    if (cond_hit) begin
      pc_d = cw.exit_pc;
    end else if (op_done) begin
      pc_d = (ctrl_o.emit && is_last) ? dpts_pkg::PC_LOAD : cw.next_pc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= dpts_pkg::PC_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* src/dpts_datapath.sv */
// Datapath of the DMA put transfer splitter: request registers, piece and
// chunk sizing, address advance and the output register. Depends on dpts_pkg.
`timescale 1ns / 1ps

module dpts_datapath #(
  parameter int MAX_DMA_BYTES     = dpts_pkg::MAX_DMA_BYTES_DEF,
  parameter int MAX_REQUEST_BYTES = dpts_pkg::MAX_REQUEST_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  dpts_pkg::dpts_in_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output dpts_pkg::dpts_out_t    out_data_o,
  input  dpts_pkg::dpts_ctrl_t   ctrl_i,
  output dpts_pkg::dpts_status_t status_o
);

  localparam int CNT_MAX   = (1 << dpts_pkg::CNT_W) - 1;
  localparam int REQ_LIM   = (MAX_REQUEST_BYTES > CNT_MAX) ? CNT_MAX : MAX_REQUEST_BYTES;
  localparam int CAP_RAW   = (MAX_DMA_BYTES / 16) * 16;
  localparam int CHUNK_CAP = (CAP_RAW < 16) ? 16 : CAP_RAW;

  localparam logic [dpts_pkg::CNT_W-1:0] REQ_LIMIT = dpts_pkg::CNT_W'(REQ_LIM);
  localparam logic [dpts_pkg::CNT_W-1:0] CAP       = dpts_pkg::CNT_W'(CHUNK_CAP);
  localparam logic [dpts_pkg::RES_W-1:0] CNT_LAST  =
    dpts_pkg::RES_W'(dpts_pkg::MAX_RESULTS - 1);

  logic [dpts_pkg::EXT_W-1:0] ea_q;
  logic [dpts_pkg::LOC_W-1:0] ls_q;
  logic [dpts_pkg::CNT_W-1:0] rem_q;
  logic [dpts_pkg::TAG_W-1:0] tag_q;
  logic                       short_q;
  logic [dpts_pkg::RES_W-1:0] cnt_q;
  logic                       out_valid_q;
  dpts_pkg::dpts_out_t        out_q;

  logic                       load;
  logic                       out_free;
  logic [dpts_pkg::CNT_W-1:0] len_clamp;
  logic                       len_short;
  logic [2:0]                 align_bits;
  logic [3:0]                 size_align;
  logic [3:0]                 size_fit;
  logic [3:0]                 piece;
  logic [dpts_pkg::CNT_W-1:0] piece_w;
  logic [dpts_pkg::CNT_W-1:0] rem16;
  logic [dpts_pkg::CNT_W-1:0] chunk_w;
  logic [dpts_pkg::CNT_W-1:0] size_w;
  logic                       cnt_full;

  assign load     = ctrl_i.load_slot && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign len_clamp = (in_data_i.byte_count > REQ_LIMIT) ? REQ_LIMIT : in_data_i.byte_count;
  assign len_short = (len_clamp < dpts_pkg::CNT_W'(16));

  // Short requests align on the local address, long ones on the external.
  assign align_bits = short_q ? ls_q[2:0] : ea_q[2:0];

  always_comb begin
    if (align_bits[0]) begin
      size_align = 4'd1;
    end else if (align_bits[1]) begin
      size_align = 4'd2;
    end else if (align_bits[2]) begin
      size_align = 4'd4;
    end else begin
      size_align = 4'd8;
    end
  end

  always_comb begin
    if (rem_q >= dpts_pkg::CNT_W'(8)) begin
      size_fit = 4'd8;
    end else if (rem_q >= dpts_pkg::CNT_W'(4)) begin
      size_fit = 4'd4;
    end else if (rem_q >= dpts_pkg::CNT_W'(2)) begin
      size_fit = 4'd2;
    end else begin
      size_fit = 4'd1;
    end
  end

  assign piece   = (size_align < size_fit) ? size_align : size_fit;
  assign piece_w = dpts_pkg::CNT_W'(piece);
  assign rem16   = {rem_q[dpts_pkg::CNT_W-1:4], 4'b0000};
  assign chunk_w = (rem16 > CAP) ? CAP : rem16;
  assign size_w  = ctrl_i.chunk ? chunk_w : piece_w;

  assign cnt_full = (cnt_q == CNT_LAST);

  assign status_o.in_valid   = in_valid_i;
  assign status_o.out_free   = out_free;
  assign status_o.rem_zero   = (rem_q == '0);
  assign status_o.is_short   = short_q;
  assign status_o.ea_aligned = (ea_q[3:0] == 4'b0000);
  assign status_o.rem_lt16   = (rem_q[dpts_pkg::CNT_W-1:4] == '0);
  assign status_o.last_piece = (rem_q == piece_w) || cnt_full;
  assign status_o.last_chunk = (rem_q == chunk_w) || cnt_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        short_q <= len_short;
        cnt_q   <= '0;
      end else if (ctrl_i.emit) begin
        cnt_q <= cnt_q + dpts_pkg::RES_W'(1);
      end
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ea_q  <= len_short ? {in_data_i.ext_addr[dpts_pkg::EXT_W-1:3], in_data_i.local_addr[2:0]}
                         : in_data_i.ext_addr;
      ls_q  <= in_data_i.local_addr;
      rem_q <= len_clamp;
      tag_q <= in_data_i.tag;
    end else if (ctrl_i.emit) begin
      ea_q  <= ea_q + dpts_pkg::EXT_W'(size_w);
      ls_q  <= ls_q + dpts_pkg::LOC_W'(size_w);
      rem_q <= rem_q - size_w;
    end
    if (ctrl_i.emit) begin
      out_q.xfer_ext_addr   <= ea_q;
      out_q.xfer_local_addr <= ls_q;
      out_q.xfer_len        <= size_w[dpts_pkg::LEN_W-1:0];
      out_q.xfer_tag        <= tag_q;
      out_q.last            <= ctrl_i.chunk ? status_o.last_chunk : status_o.last_piece;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/dma_put_transfer_splitter_top.sv */
// Top level of the DMA put transfer splitter: joins the microcode sequencer
// and the datapath. Depends on dpts_pkg, dpts_sequencer and dpts_datapath.
`timescale 1ns / 1ps

// The splitter takes one put request (external address, local address, byte
// count, tag) and produces the run of DMA transfers the engine accepts, one
// transfer per cycle while the output is not stalled. A zero byte count gives
// no transfers. Counts under 16 are cut into naturally aligned 1, 2, 4 or
// 8-byte pieces placed by the low three bits of the local address, with the
// external address rounded down to 8 bytes and given the same offset. Longer
// counts get 1/2/4/8-byte pieces up to 16-byte external alignment, then
// 16-byte-multiple chunks of at most MAX_DMA_BYTES (rounded down to 16), then
// an 8/4/2/1 tail. Counts above MAX_REQUEST_BYTES are clamped, and at most
// 16 transfers are produced per request; the sixteenth then carries last and
// the rest of the bytes are dropped. The final transfer of each request has
// last set. A request with a zero count passes only through the load and
// empty-check steps. Any other request occupies the block for its number of
// transfers plus the load step and each step of the microcode program that
// leaves a loop or picks a path without emitting; output stalls add to that.
// The input is accepted only in the program's load step, and the registered
// output lets the next request be accepted while the final transfer still
// waits to be taken.
module dma_put_transfer_splitter_top #(
  parameter int MAX_DMA_BYTES     = dpts_pkg::MAX_DMA_BYTES_DEF,
  parameter int MAX_REQUEST_BYTES = dpts_pkg::MAX_REQUEST_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dpts_pkg::dpts_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dpts_pkg::dpts_out_t out_data_o
);

  dpts_pkg::dpts_ctrl_t   ctrl;
  dpts_pkg::dpts_status_t status;

  // The sequencer walks the program and issues load and emit strobes.
  dpts_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // The datapath holds the request, sizes each transfer and owns the
  // output register.
  dpts_datapath #(
    .MAX_DMA_BYTES     (MAX_DMA_BYTES),
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .status_o    (status)
  );

  // A request transfer is taken only in the load step.
  assign in_stall_o = !ctrl.load_slot;

endmodule
